>>> rtl/elb_pkg.sv
// Shared widths, constants, register indexes and the multiply-accumulate command type
// for the EMA/PID load-ratio balancer. No dependencies; every other file imports it.
`default_nettype none

package elb_pkg;

  localparam int TIME_W     = 24;
  localparam int TEMP_W     = 12;
  localparam int SHARE_W    = 15;
  localparam int GAIN_W     = 16;
  localparam int AVG_W      = 32;
  localparam int ERR_W      = 25;
  localparam int INTEG_W    = 18;
  localparam int DERIV_W    = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Shared multiplier: signed 33 x signed 18, accumulated into 60 bits.
  localparam int MAC_A_W  = 33;
  localparam int MAC_B_W  = 18;
  localparam int MAC_P_W  = MAC_A_W + MAC_B_W;
  localparam int ACC_W    = 60;
  localparam int HI_SHIFT = 22;

  // Divider: Q12.20 dividend shifted by 16, 24 quotient bits.
  localparam int REM_W = AVG_W + 16;
  localparam int DSH_W = REM_W + 8;
  localparam int QUO_W = 24;

  localparam logic [AVG_W-1:0]          AVG_FLOOR   = 32'd1049;
  localparam logic [GAIN_W-1:0]         HUNDREDTH   = 16'd655;
  localparam logic [GAIN_W-1:0]         TENTH       = 16'd6554;
  localparam logic [SHARE_W-1:0]        SHARE_MIN   = 15'd3277;
  localparam logic [SHARE_W-1:0]        SHARE_MAX   = 15'd29491;
  localparam logic [SHARE_W-1:0]        SHARE_RESET = 15'd16384;
  localparam logic signed [ERR_W-1:0]   ERR_LIM     = 25'sd8388608;
  localparam logic [GAIN_W-1:0]         PROP_RESET  = 16'd3277;
  localparam logic [GAIN_W-1:0]         INTEG_RESET = 16'd655;
  localparam logic [GAIN_W-1:0]         DERIV_RESET = 16'd0;
  localparam logic [GAIN_W-1:0]         ALPHA_RESET = 16'd58982;
  localparam logic [TEMP_W-1:0]         TEMP_RESET  = 12'd1360;
  localparam logic [SHARE_W-1:0]        HEAT_RESET  = 15'd3277;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN       = 3'd0,
    REG_INTEG_GAIN      = 3'd1,
    REG_DERIV_GAIN      = 3'd2,
    REG_SMOOTHING_ALPHA = 3'd3,
    REG_TEMP_LIMIT      = 3'd4,
    REG_HEAT_PENALTY    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                       issue;
    logic                       clear;
    logic                       shift_hi;
    logic signed [MAC_A_W-1:0]  a;
    logic signed [MAC_B_W-1:0]  b;
  } mac_cmd_t;

endpackage

`default_nettype wire

>>> rtl/elb_if.sv
// Valid/ready channel interfaces for the sample items and the share results.
// Depends on elb_pkg for the field widths.
`default_nettype none

interface elb_item_if import elb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [TIME_W-1:0]  cpu_time;
  logic [TIME_W-1:0]  gpu_time;
  logic [TEMP_W-1:0]  cpu_temp;
  logic [TEMP_W-1:0]  gpu_temp;
  logic               temps_valid;
  logic [SHARE_W-1:0] share_value;

  modport source (output valid, action, cpu_time, gpu_time, cpu_temp, gpu_temp,
                  temps_valid, share_value, input ready);
  modport sink   (input valid, action, cpu_time, gpu_time, cpu_temp, gpu_temp,
                  temps_valid, share_value, output ready);
endinterface

interface elb_result_if import elb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SHARE_W-1:0] cpu_share;

  modport source (output valid, cpu_share, input ready);
  modport sink   (input valid, cpu_share, output ready);
endinterface

`default_nettype wire

>>> rtl/elb_mac.sv
// Shared multiply-accumulate unit: one registered signed product per cycle, then
// an accumulate (optionally shifted up) of it in the next cycle. Depends on elb_pkg.
`default_nettype none

module elb_mac import elb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_cmd_t                cmd,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [MAC_A_W-1:0] op_a;
  logic signed [MAC_B_W-1:0] op_b;
  logic signed [MAC_P_W-1:0] prod_w;
  logic signed [MAC_P_W-1:0] prod;
  logic                      pend;
  logic                      pclear;
  logic                      phi;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   addend;
  logic signed [ACC_W-1:0]   base;

  assign op_a   = cmd.a;
  assign op_b   = cmd.b;
  assign prod_w = op_a * op_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod   <= prod_w;
    pclear <= cmd.clear;
    phi    <= cmd.shift_hi;
  end

  assign prod_ext = {{(ACC_W-MAC_P_W){prod[MAC_P_W-1]}}, prod};
  assign addend   = phi ? (prod_ext <<< HI_SHIFT) : prod_ext;
  assign base     = pclear ? '0 : acc;

  // The first operation of every sum clears, so the accumulator needs no reset.
  always_ff @(posedge clk) begin
    if (pend) begin
      acc <= base + addend;
    end
  end

endmodule

`default_nettype wire

>>> rtl/elb_div.sv
// Restoring divider, one quotient bit per cycle, that forms the saturated error
// floor(cpu_average * 2^16 / gpu_average) - 1.0 in Q9.16. Depends on elb_pkg.
`default_nettype none

module elb_div import elb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [AVG_W-1:0]        dividend,
  input  logic [AVG_W-1:0]        divisor,
  output logic                    done,
  output logic signed [ERR_W-1:0] quot_err
);

  localparam logic [QUO_W-1:0] SAT_QUO = 24'd8454144;
  localparam logic [ERR_W-1:0] ONE_Q16 = 25'd65536;
  localparam int               CNT_W   = $clog2(QUO_W);

  typedef enum logic {D_IDLE, D_RUN} div_state_t;

  div_state_t         state;
  logic [REM_W-1:0]   rem;
  logic [DSH_W-1:0]   dsh;
  logic [QUO_W-2:0]   quo;
  logic [CNT_W-1:0]   cnt;
  logic               ge;
  logic               too_big;
  logic [QUO_W-1:0]   q_fin;
  logic [ERR_W-1:0]   err_fin;

  assign ge      = {{(DSH_W-REM_W){1'b0}}, rem} >= dsh;
  assign too_big = {8'b0, dividend} >= {divisor, 8'b0};
  assign q_fin   = {quo, ge};

  always_comb begin
    if (q_fin > SAT_QUO) begin
      err_fin = ERR_LIM;
    end else begin
      err_fin = {1'b0, q_fin} - ONE_Q16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      // done pulses for one cycle, on the early exit or after the last quotient step.
      done <= ((state == D_IDLE) && start && too_big) || ((state == D_RUN) && (cnt == '0));
      unique case (state)
        D_IDLE: begin
          if (start) begin
            // A quotient of 2^24 or more saturates anyway, so skip the iterations.
            if (too_big) begin
              quot_err <= ERR_LIM;
            end else begin
              rem   <= {dividend, 16'b0};
              dsh   <= {1'b0, divisor, 23'b0};
              quo   <= '0;
              cnt   <= CNT_W'(QUO_W - 1);
              state <= D_RUN;
            end
          end
        end
        D_RUN: begin
          if (ge) begin
            rem <= rem - dsh[REM_W-1:0];
          end
          quo <= {quo[QUO_W-3:0], ge};
          dsh <= dsh >> 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            quot_err <= err_fin;
            state    <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/ema_pid_load_ratio_balancer_unit.sv
// Top level of the EMA/PID load-ratio balancer: configuration registers, the
// sequencer, and instances of elb_mac and elb_div. Depends on elb_pkg and elb_if.
//
// Usage: sample and overwrite items arrive on the item channel (valid/ready); each
// one yields exactly one cpu_share transaction on the result channel. Gains, EMA
// weight, temperature limit and heat penalty are written through cfg_write,
// cfg_index and cfg_data while the block is idle; indexes 6 and 7 are ignored.
// Work on an item runs through one shared 33 x 18 multiply-accumulate unit and a
// one-bit-per-cycle divider, so only one item is in flight. An overwrite goes
// straight to the result; a sample whose averages are both below 0.001 ms leaves
// the share as it is; one whose GPU average is at or below 0.001 ms skips the
// division; the divider exits early when the CPU average is at least 256 times the
// GPU average; otherwise it runs a full division of 24 quotient steps. A new item
// is accepted in the cycle after the result is loaded into the output register.
// The result sits in an output register; if the receiver stalls, the block
// finishes the next item and then waits until that register is free. Reset is
// synchronous: averages, integral and last error clear, the share returns to one
// half and the registers take their defaults.
`default_nettype none

module ema_pid_load_ratio_balancer_unit import elb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  elb_item_if.sink              item,
  elb_result_if.source          result
);

  typedef enum logic [4:0] {
    S_IDLE, S_EMA_C0, S_EMA_C1, S_EMA_G0, S_EMA_G1, S_EMA_W, S_EMA_END,
    S_DIV_GO, S_DIV_WAIT, S_INT0, S_INT1, S_INT2,
    S_PID0, S_PID1, S_PID2, S_PID3, S_PID4, S_PID5, S_PID6, S_PID7, S_FIN
  } seq_state_t;

  // Configuration registers
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  integ_gain;
  logic [GAIN_W-1:0]  deriv_gain;
  logic [GAIN_W-1:0]  smoothing_alpha;
  logic [TEMP_W-1:0]  temp_limit;
  logic [SHARE_W-1:0] heat_penalty;

  // Controller state
  seq_state_t                 state;
  logic [AVG_W-1:0]           cpu_average;
  logic [AVG_W-1:0]           gpu_average;
  logic signed [INTEG_W-1:0]  integral_sum;
  logic signed [ERR_W-1:0]    last_error;
  logic [SHARE_W-1:0]         share;

  // Working registers for the item in flight
  logic [TIME_W-1:0]          cpu_time_q;
  logic [TIME_W-1:0]          gpu_time_q;
  logic [TEMP_W-1:0]          cpu_temp_q;
  logic [TEMP_W-1:0]          gpu_temp_q;
  logic                       temps_valid_q;
  logic signed [ERR_W-1:0]    err_q;
  logic signed [DERIV_W-1:0]  deriv;
  logic                       res_valid;
  logic [SHARE_W-1:0]         res_share;

  mac_cmd_t                   mac_cmd;
  logic signed [ACC_W-1:0]    mac_acc;
  logic                       div_start;
  logic                       div_done;
  logic signed [ERR_W-1:0]    div_err;

  logic [16:0]                alpha_c;
  logic [REM_W-1:0]           ema_rnd;
  logic [AVG_W-1:0]           ema_avg;
  logic signed [ACC_W-1:0]    i_rnd;
  logic signed [INTEG_W:0]    integ_inc;
  logic signed [INTEG_W+1:0]  integ_sum;
  logic signed [INTEG_W-1:0]  integ_new;
  logic signed [ACC_W-1:0]    s_rnd;
  logic signed [21:0]         delta;
  logic signed [23:0]         share_calc;
  logic [SHARE_W-1:0]         share_new;
  logic [SHARE_W-1:0]         share_ovr;
  logic                       hot_cpu;
  logic                       hot_gpu;

  elb_mac u_mac (
    .clk (clk),
    .rst (rst),
    .cmd (mac_cmd),
    .acc (mac_acc)
  );

  elb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cpu_average),
    .divisor  (gpu_average),
    .done     (div_done),
    .quot_err (div_err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= PROP_RESET;
      integ_gain      <= INTEG_RESET;
      deriv_gain      <= DERIV_RESET;
      smoothing_alpha <= ALPHA_RESET;
      temp_limit      <= TEMP_RESET;
      heat_penalty    <= HEAT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PROP_GAIN:       prop_gain       <= cfg_data;
        REG_INTEG_GAIN:      integ_gain      <= cfg_data;
        REG_DERIV_GAIN:      deriv_gain      <= cfg_data;
        REG_SMOOTHING_ALPHA: smoothing_alpha <= cfg_data;
        REG_TEMP_LIMIT:      temp_limit      <= cfg_data[TEMP_W-1:0];
        REG_HEAT_PENALTY:    heat_penalty    <= cfg_data[SHARE_W-1:0];
        default: ;
      endcase
    end
  end

  assign alpha_c = 17'h10000 - {1'b0, smoothing_alpha};

  // Operations issued to the shared unit; a result reaches the accumulator through
  // the product register and then the accumulator register.
  always_comb begin
    mac_cmd = '0;
    unique case (state)
      S_EMA_C0: begin
        mac_cmd.issue = 1'b1;
        mac_cmd.clear = 1'b1;
        mac_cmd.a     = {1'b0, cpu_average};
        mac_cmd.b     = {2'b0, smoothing_alpha};
      end
      S_EMA_C1: begin
        mac_cmd.issue = 1'b1;
        mac_cmd.a     = {1'b0, cpu_time_q, 8'b0};
        mac_cmd.b     = {1'b0, alpha_c};
      end
      S_EMA_G0: begin
        mac_cmd.issue = 1'b1;
        mac_cmd.clear = 1'b1;
        mac_cmd.a     = {1'b0, gpu_average};
        mac_cmd.b     = {2'b0, smoothing_alpha};
      end
      S_EMA_G1: begin
        mac_cmd.issue = 1'b1;
        mac_cmd.a     = {1'b0, gpu_time_q, 8'b0};
        mac_cmd.b     = {1'b0, alpha_c};
      end
      S_INT0: begin
        mac_cmd.issue = 1'b1;
        mac_cmd.clear = 1'b1;
        mac_cmd.a     = {{(MAC_A_W-ERR_W){err_q[ERR_W-1]}}, err_q};
        mac_cmd.b     = {2'b0, HUNDREDTH};
      end
      S_PID0: begin
        mac_cmd.issue = 1'b1;
        mac_cmd.clear = 1'b1;
        mac_cmd.a     = {{(MAC_A_W-ERR_W){err_q[ERR_W-1]}}, err_q};
        mac_cmd.b     = {2'b0, prop_gain};
      end
      S_PID1: begin
        mac_cmd.issue = 1'b1;
        mac_cmd.a     = {{(MAC_A_W-INTEG_W){integral_sum[INTEG_W-1]}}, integral_sum};
        mac_cmd.b     = {2'b0, integ_gain};
      end
      S_PID2: begin
        mac_cmd.issue = 1'b1;
        mac_cmd.a     = {{(MAC_A_W-DERIV_W){deriv[DERIV_W-1]}}, deriv};
        mac_cmd.b     = {2'b0, deriv_gain};
      end
      S_PID4: begin
        // The PID sum is scaled by 0.1 in two halves: low 22 bits first.
        mac_cmd.issue = 1'b1;
        mac_cmd.clear = 1'b1;
        mac_cmd.a     = {{(MAC_A_W-HI_SHIFT){1'b0}}, mac_acc[HI_SHIFT-1:0]};
        mac_cmd.b     = {2'b0, TENTH};
      end
      S_PID5: begin
        mac_cmd.issue    = 1'b1;
        mac_cmd.shift_hi = 1'b1;
        mac_cmd.a        = {{(MAC_A_W-22){mac_acc[2*HI_SHIFT-1]}},
                            mac_acc[2*HI_SHIFT-1:HI_SHIFT]};
        mac_cmd.b        = {2'b0, TENTH};
      end
      default: mac_cmd = '0;
    endcase
  end

  assign div_start = (state == S_DIV_GO);

  // EMA rounding; the sum never exceeds 2^48, so 48 bits carry it.
  assign ema_rnd = mac_acc[REM_W-1:0] + REM_W'(32768);
  assign ema_avg = ema_rnd[REM_W-1:16];

  // Integral step: round(err * 0.01) added and clamped to +-1.0.
  assign i_rnd     = mac_acc + ACC_W'(32768);
  assign integ_inc = i_rnd[34:16];
  assign integ_sum = {{2{integral_sum[INTEG_W-1]}}, integral_sum}
                   + {integ_inc[INTEG_W], integ_inc};

  always_comb begin
    if (integ_sum > 20'sd65536) begin
      integ_new = 18'sd65536;
    end else if (integ_sum < -20'sd65536) begin
      integ_new = -18'sd65536;
    end else begin
      integ_new = integ_sum[INTEG_W-1:0];
    end
  end

  // Share update: round(pid * 0.1 / 2^17), heat penalties, then the 0.1..0.9 clamp.
  assign s_rnd   = mac_acc + (ACC_W'(1) << 32);
  assign delta   = s_rnd[54:33];
  assign hot_cpu = temps_valid_q && (cpu_temp_q > temp_limit);
  assign hot_gpu = temps_valid_q && (gpu_temp_q > temp_limit);

  always_comb begin
    share_calc = {9'b0, share} - {{2{delta[21]}}, delta};
    if (hot_gpu) begin
      share_calc = share_calc + {9'b0, heat_penalty};
    end
    if (hot_cpu) begin
      share_calc = share_calc - {9'b0, heat_penalty};
    end
    if (share_calc < 24'sd3277) begin
      share_new = SHARE_MIN;
    end else if (share_calc > 24'sd29491) begin
      share_new = SHARE_MAX;
    end else begin
      share_new = share_calc[SHARE_W-1:0];
    end
  end

  always_comb begin
    if (item.share_value < SHARE_MIN) begin
      share_ovr = SHARE_MIN;
    end else if (item.share_value > SHARE_MAX) begin
      share_ovr = SHARE_MAX;
    end else begin
      share_ovr = item.share_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      res_valid    <= 1'b0;
      cpu_average  <= '0;
      gpu_average  <= '0;
      integral_sum <= '0;
      last_error   <= '0;
      share        <= SHARE_RESET;
    end else begin
      if (state == S_FIN && (!res_valid || result.ready)) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            cpu_time_q    <= item.cpu_time;
            gpu_time_q    <= item.gpu_time;
            cpu_temp_q    <= item.cpu_temp;
            gpu_temp_q    <= item.gpu_temp;
            temps_valid_q <= item.temps_valid;
            if (item.action) begin
              share <= share_ovr;
              state <= S_FIN;
            end else begin
              state <= S_EMA_C0;
            end
          end
        end
        S_EMA_C0: state <= S_EMA_C1;
        S_EMA_C1: state <= S_EMA_G0;
        S_EMA_G0: state <= S_EMA_G1;
        S_EMA_G1: begin
          cpu_average <= ema_avg;
          state       <= S_EMA_W;
        end
        S_EMA_W: state <= S_EMA_END;
        S_EMA_END: begin
          gpu_average <= ema_avg;
          if (cpu_average < AVG_FLOOR && ema_avg < AVG_FLOOR) begin
            state <= S_FIN;
          end else if (ema_avg > AVG_FLOOR) begin
            state <= S_DIV_GO;
          end else begin
            err_q <= '0;
            state <= S_INT0;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            err_q <= div_err;
            state <= S_INT0;
          end
        end
        S_INT0: state <= S_INT1;
        S_INT1: state <= S_INT2;
        S_INT2: begin
          integral_sum <= integ_new;
          deriv        <= {err_q[ERR_W-1], err_q} - {last_error[ERR_W-1], last_error};
          last_error   <= err_q;
          state        <= S_PID0;
        end
        S_PID0: state <= S_PID1;
        S_PID1: state <= S_PID2;
        S_PID2: state <= S_PID3;
        S_PID3: state <= S_PID4;
        S_PID4: state <= S_PID5;
        S_PID5: state <= S_PID6;
        S_PID6: state <= S_PID7;
        S_PID7: begin
          share <= share_new;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!res_valid || result.ready) begin
            res_share <= share;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item.ready       = (state == S_IDLE) && !rst;
  assign result.valid     = res_valid;
  assign result.cpu_share = res_share;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the EMA/PID load-ratio balancer: a directed table, then random
// phases with idling, back-pressure and register changes, checked against a cycle-free predictor.
// Depends on elb_pkg, the elb_item_if/elb_result_if interfaces and the RTL of the unit.
`timescale 1ns / 100ps

module tb_top;
  import elb_pkg::*;

  localparam logic ACT_SAMPLE    = 1'b0;
  localparam logic ACT_OVERWRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [TEMP_W-1:0] TEMP_MAX = '1;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 100;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    logic               action;
    logic [TIME_W-1:0]  cpu_time;
    logic [TIME_W-1:0]  gpu_time;
    logic [TEMP_W-1:0]  cpu_temp;
    logic [TEMP_W-1:0]  gpu_temp;
    logic               temps_valid;
    logic [SHARE_W-1:0] share_value;
  } item_t;

  typedef struct packed {
    row_kind_t             kind;
    item_t                 item;
    logic                  has_fixed;
    logic [SHARE_W-1:0]    fixed_share;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  elb_item_if   item_ch ();
  elb_result_if res_ch ();

  ema_pid_load_ratio_balancer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (res_ch)
  );

  always #1 clk = ~clk;

  // Predictor copy of the registers and the controller state
  logic [GAIN_W-1:0]  kp_reg, ki_reg, kd_reg, alpha_reg;
  logic [TEMP_W-1:0]  hot_limit_reg;
  logic [SHARE_W-1:0] penalty_reg;
  logic [AVG_W-1:0]   cpu_ema, gpu_ema;
  longint             integ_acc, prev_err, share_now;

  logic [SHARE_W-1:0] share_expect_q [$];
  logic [SHARE_W-1:0] share_want;
  stim_row_t          dir_rows [$];

  int   fail_count   = 0;
  int   cycle_count  = 0;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  bit   pressure_on  = 1'b0;
  logic rx_hold;

  function automatic longint clamp_s(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Round half up, which for a signed value is a floor after adding the half.
  function automatic longint round_shift(input longint x, input int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic [AVG_W-1:0] ema_update(input logic [AVG_W-1:0] avg,
                                                  input logic [TIME_W-1:0] t);
    logic [63:0] acc;
    acc = 64'(avg) * 64'(alpha_reg) + (64'(t) << 8) * (64'd65536 - 64'(alpha_reg));
    return AVG_W'((acc + 64'd32768) >> 16);
  endfunction

  function automatic logic [SHARE_W-1:0] step_balancer(input item_t it);
    longint err, deriv, pid, quo;
    if (it.action == ACT_OVERWRITE) begin
      share_now = longint'(it.share_value);
    end else begin
      cpu_ema = ema_update(cpu_ema, it.cpu_time);
      gpu_ema = ema_update(gpu_ema, it.gpu_time);
      // Nothing moves while both averages sit below the floor.
      if (cpu_ema >= AVG_FLOOR || gpu_ema >= AVG_FLOOR) begin
        err = 0;
        if (gpu_ema > AVG_FLOOR) begin
          quo = (longint'(cpu_ema) << 16) / longint'(gpu_ema);
          if (quo > longint'(ERR_LIM) + 65536) quo = longint'(ERR_LIM) + 65536;
          err = quo - 65536;
        end
        integ_acc = clamp_s(integ_acc + round_shift(err * longint'(HUNDREDTH), 16),
                            -64'sd65536, 64'sd65536);
        deriv     = err - prev_err;
        prev_err  = err;
        pid = longint'(kp_reg) * err + longint'(ki_reg) * integ_acc
            + longint'(kd_reg) * deriv;
        share_now = share_now - round_shift(pid * longint'(TENTH), 33);
        if (it.temps_valid) begin
          if (it.gpu_temp > hot_limit_reg) share_now = share_now + longint'(penalty_reg);
          if (it.cpu_temp > hot_limit_reg) share_now = share_now - longint'(penalty_reg);
        end
      end
    end
    share_now = clamp_s(share_now, longint'(SHARE_MIN), longint'(SHARE_MAX));
    return SHARE_W'(share_now);
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(9))
      0, 1:    return TIME_W'($urandom_range(32'hFFFFFF));
      2:       return TIME_W'($urandom_range(8));
      3:       return TIME_MAX - TIME_W'($urandom_range(255));
      default: return TIME_W'($urandom_range(40 * 4096, 4096));
    endcase
  endfunction

  function automatic logic [TEMP_W-1:0] pick_temp();
    int v;
    if ($urandom_range(1) == 0) return TEMP_W'($urandom_range(4095));
    v = int'(hot_limit_reg) + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return TEMP_W'(v);
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.action      = ($urandom_range(99) < 15) ? ACT_OVERWRITE : ACT_SAMPLE;
    it.cpu_time    = pick_time();
    it.gpu_time    = pick_time();
    it.cpu_temp    = pick_temp();
    it.gpu_temp    = pick_temp();
    it.temps_valid = 1'($urandom_range(1));
    it.share_value = SHARE_W'($urandom_range(32767));
    return it;
  endfunction

  function automatic stim_row_t sample_row(input logic [TIME_W-1:0] c, g,
                                           input logic [TEMP_W-1:0] ct, gt,
                                           input logic tv, input logic has,
                                           input logic [SHARE_W-1:0] fixed);
    stim_row_t r;
    r                  = '0;
    r.kind             = ROW_ITEM;
    r.item.action      = ACT_SAMPLE;
    r.item.cpu_time    = c;
    r.item.gpu_time    = g;
    r.item.cpu_temp    = ct;
    r.item.gpu_temp    = gt;
    r.item.temps_valid = tv;
    r.item.share_value = '1;
    r.has_fixed        = has;
    r.fixed_share      = fixed;
    return r;
  endfunction

  // Fields that an overwrite ignores are held at their maximum.
  function automatic stim_row_t overwrite_row(input logic [SHARE_W-1:0] v,
                                              input logic [SHARE_W-1:0] fixed);
    stim_row_t r;
    r                  = '0;
    r.kind             = ROW_ITEM;
    r.item.action      = ACT_OVERWRITE;
    r.item.cpu_time    = TIME_MAX;
    r.item.gpu_time    = TIME_MAX;
    r.item.cpu_temp    = TEMP_MAX;
    r.item.gpu_temp    = TEMP_MAX;
    r.item.temps_valid = 1'b1;
    r.item.share_value = v;
    r.has_fixed        = 1'b1;
    r.fixed_share      = fixed;
    return r;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r          = '0;
    r.kind     = ROW_WRITE;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  task automatic report_fail(input string msg);
    if (fail_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PROP_GAIN:       kp_reg        = data;
      REG_INTEG_GAIN:      ki_reg        = data;
      REG_DERIV_GAIN:      kd_reg        = data;
      REG_SMOOTHING_ALPHA: alpha_reg     = data;
      REG_TEMP_LIMIT:      hot_limit_reg = data[TEMP_W-1:0];
      REG_HEAT_PENALTY:    penalty_reg   = data[SHARE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drop valid and wait until every outstanding transaction has returned.
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (share_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(input item_t it, input logic has_fixed,
                           input logic [SHARE_W-1:0] fixed_share);
    logic [SHARE_W-1:0] predicted;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    item_ch.valid       <= 1'b1;
    item_ch.action      <= it.action;
    item_ch.cpu_time    <= it.cpu_time;
    item_ch.gpu_time    <= it.gpu_time;
    item_ch.cpu_temp    <= it.cpu_temp;
    item_ch.gpu_temp    <= it.gpu_temp;
    item_ch.temps_valid <= it.temps_valid;
    item_ch.share_value <= it.share_value;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predicted = step_balancer(it);
    share_expect_q.push_back(has_fixed ? fixed_share : predicted);
  endtask

  task automatic load_config(input logic [CFG_DATA_W-1:0] p, i, d, a, t, h);
    settle();
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_SMOOTHING_ALPHA, a);
    write_reg(REG_TEMP_LIMIT, t);
    write_reg(REG_HEAT_PENALTY, h);
    write_reg(REG_UNUSED_6, CFG_DATA_W'($urandom_range(65535)));
    write_reg(REG_UNUSED_7, CFG_DATA_W'($urandom_range(65535)));
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    repeat (count) send_item(rand_item(), 1'b0, '0);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_reg();
    return CFG_DATA_W'($urandom_range(65535));
  endfunction

  // Result side: check each transaction, then decide whether to stall the next cycle.
  always @(posedge clk) begin
    if (res_ch.valid && res_ch.ready) begin
      if (share_expect_q.size() == 0) begin
        report_fail($sformatf("cpu_share %0d with no transaction outstanding",
                              res_ch.cpu_share));
      end else begin
        share_want = share_expect_q.pop_front();
        if (res_ch.cpu_share !== share_want)
          report_fail($sformatf("cpu_share got %0d, expected %0d", res_ch.cpu_share,
                                share_want));
      end
    end
    res_ch.ready <= !rst && !rx_hold &&
                    !(rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
  end

  // Long receiver hold-off, so that the unit fills up and stalls its input.
  initial begin
    rx_hold <= 1'b0;
    wait (pressure_on);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit of %0d reached with %0d transactions outstanding", CYCLE_LIMIT,
               share_expect_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst                 <= 1'b1;
    cfg_write           <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.action      <= ACT_SAMPLE;
    item_ch.cpu_time    <= '0;
    item_ch.gpu_time    <= '0;
    item_ch.cpu_temp    <= '0;
    item_ch.gpu_temp    <= '0;
    item_ch.temps_valid <= 1'b0;
    item_ch.share_value <= '0;

    kp_reg        = PROP_RESET;
    ki_reg        = INTEG_RESET;
    kd_reg        = DERIV_RESET;
    alpha_reg     = ALPHA_RESET;
    hot_limit_reg = TEMP_RESET;
    penalty_reg   = HEAT_RESET;
    cpu_ema       = '0;
    gpu_ema       = '0;
    integ_acc     = 0;
    prev_err      = 0;
    share_now     = longint'(SHARE_RESET);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A zero sample straight after reset is skipped and leaves the share at
    // one half. With this weight a time of 5 puts both averages exactly on the floor.
    dir_rows.push_back(sample_row('0, '0, '0, '0, 1'b0, 1'b1, SHARE_RESET));
    dir_rows.push_back(write_row(REG_SMOOTHING_ALPHA, 16'd11826));
    dir_rows.push_back(sample_row(24'd5, 24'd5, '0, '0, 1'b0, 1'b0, '0));
    dir_rows.push_back(write_row(REG_SMOOTHING_ALPHA, ALPHA_RESET));
    dir_rows.push_back(overwrite_row('0, SHARE_MIN));
    dir_rows.push_back(overwrite_row('1, SHARE_MAX));
    dir_rows.push_back(overwrite_row(15'd29492, SHARE_MAX));
    dir_rows.push_back(overwrite_row(15'd3276, SHARE_MIN));
    dir_rows.push_back(overwrite_row(SHARE_RESET, SHARE_RESET));
    dir_rows.push_back(sample_row(TIME_MAX, '0, '0, '0, 1'b1, 1'b0, '0));
    dir_rows.push_back(sample_row(TIME_MAX, TIME_MAX, TEMP_MAX, TEMP_MAX, 1'b0, 1'b0, '0));
    dir_rows.push_back(sample_row(24'd1, TIME_MAX, '0, '0, 1'b0, 1'b0, '0));
    dir_rows.push_back(sample_row(TIME_MAX, TIME_MAX, '0, TEMP_MAX, 1'b1, 1'b0, '0));
    dir_rows.push_back(sample_row(TIME_MAX, TIME_MAX, TEMP_MAX, '0, 1'b1, 1'b0, '0));
    dir_rows.push_back(sample_row(TIME_MAX, TIME_MAX, TEMP_RESET, TEMP_RESET, 1'b1, 1'b0, '0));
    dir_rows.push_back(sample_row(TIME_MAX, TIME_MAX, TEMP_RESET + 12'd1, TEMP_RESET + 12'd1,
                                  1'b1, 1'b0, '0));
    // With no smoothing a huge CPU time over a tiny GPU time saturates the ratio.
    dir_rows.push_back(write_row(REG_SMOOTHING_ALPHA, '0));
    dir_rows.push_back(sample_row(TIME_MAX, 24'd6, '0, '0, 1'b0, 1'b0, '0));
    dir_rows.push_back(write_row(REG_DERIV_GAIN, '1));
    dir_rows.push_back(sample_row(24'd6, TIME_MAX, '0, '0, 1'b0, 1'b0, '0));
    dir_rows.push_back(write_row(REG_UNUSED_6, '1));
    dir_rows.push_back(write_row(REG_UNUSED_7, '0));
    dir_rows.push_back(sample_row(TIME_MAX, 24'd4096, 12'd2000, 12'd100, 1'b1, 1'b0, '0));
    dir_rows.push_back(write_row(REG_SMOOTHING_ALPHA, ALPHA_RESET));
    dir_rows.push_back(write_row(REG_DERIV_GAIN, DERIV_RESET));

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_data);
      end else begin
        send_item(dir_rows[r].item, dir_rows[r].has_fixed, dir_rows[r].fixed_share);
      end
    end

    // Random phases under several register settings, the extremes among them.
    run_phase(0, 0, 250);
    load_config('1, '1, '1, '0, '1, '1);
    run_phase(63, 0, 220);
    load_config('0, '0, '0, '1, '0, '0);
    run_phase(0, 63, 120);
    load_config(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
    run_phase(29, 29, 250);
    load_config(PROP_RESET, INTEG_RESET, DERIV_RESET, ALPHA_RESET, TEMP_RESET, HEAT_RESET);
    pressure_on = 1'b1;
    run_phase(0, 0, 40);
    load_config(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
    run_phase(0, 0, 200);
    load_config(rand_reg(), rand_reg(), 16'd40000, 16'd32768, 16'd1360, rand_reg());
    run_phase(63, 0, 200);
    load_config(16'd3277, 16'd655, 16'd20000, 16'd32768, 16'd1360, 16'd3277);
    run_phase(0, 63, 180);
    load_config(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
    run_phase(29, 29, 200);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/elb_pkg.sv
rtl/elb_if.sv
rtl/elb_mac.sv
rtl/elb_div.sv
rtl/ema_pid_load_ratio_balancer_unit.sv
dv/tb_top.sv
